>>> design/can_vehicle_speed_decoder_defines.svh
// Assertion macros for the CAN vehicle speed decoder.
`ifndef CAN_VEHICLE_SPEED_DECODER_DEFINES_SVH
`define CAN_VEHICLE_SPEED_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define CVSD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("cvsd: implication check failed");
`define CVSD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("cvsd: next-cycle check failed");
`else
`define CVSD_ASSERT_IMP(label, ante, cons)
`define CVSD_ASSERT_NXT(label, ante, cons)
`endif
`endif

>>> design/cvsd_pkg.sv
// Types, codes and constants shared by the CAN vehicle speed decoder.
package cvsd_pkg;

    localparam int SPEED_FRAC_BITS_DEF = 10;
    localparam int SPD_W   = 26;
    localparam int RAW_W   = 16;
    localparam int SCALE_W = 16;
    localparam int LANES   = 4;
    localparam int SHIFT_W = 34;   // gain product after the widest fraction shift
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd16384;

    localparam logic [10:0] ID_REAR_PAIR   = 11'h1F0;
    localparam logic [10:0] ID_SPEED_12    = 11'h1A0;
    localparam logic [10:0] ID_WHEEL_LE    = 11'h0CE;
    localparam logic [10:0] ID_SPEED_BE    = 11'h200;
    localparam logic [10:0] ID_WHEEL_BE    = 11'h4B0;

    localparam logic [RAW_W-1:0] WHEEL_OFFSET = 16'd10000;

    // x/10 and x/100 for any 32-bit x by reciprocal multiply
    localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;
    localparam logic [31:0] RECIP_100  = 32'h51EB_851F;
    localparam int          SHIFT_10   = 35;
    localparam int          SHIFT_100  = 37;

    typedef enum logic [1:0] {
        REG_ENABLE       = 2'd0,
        REG_VEHICLE_TYPE = 2'd1,
        REG_WSS_MODE     = 2'd2,
        REG_SPEED_SCALE  = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        VT_REAR_PAIR   = 2'd0,
        VT_DUAL_ID     = 2'd1,
        VT_BE_WORD     = 2'd2,
        VT_WHEEL_OFFS  = 2'd3
    } vt_t;

    typedef enum logic [1:0] {
        WSS_DIRECT = 2'd0,
        WSS_FRONT  = 2'd1,
        WSS_REAR   = 2'd2,
        WSS_ALL    = 2'd3
    } wss_t;

    typedef enum logic [1:0] {
        DEN_1   = 2'd0,
        DEN_10  = 2'd1,
        DEN_16  = 2'd2,
        DEN_100 = 2'd3
    } den_t;

    typedef struct packed {
        logic               enable;
        vt_t                vehicle_type;
        wss_t               wss_mode;
        logic [SCALE_W-1:0] speed_scale;
    } cfg_t;

    typedef struct packed {
        logic [RAW_W-1:0] mag;
        logic             neg;
    } lane_raw_t;

    typedef struct packed {
        logic speed_ok;
        logic wheels_ok;
    } frame_flags_t;

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

>>> design/cvsd_apb_regs.sv
// APB configuration registers of the CAN vehicle speed decoder.
module cvsd_apb_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [cvsd_pkg::ADDR_W-1:0] paddr,
    input  logic [cvsd_pkg::DATA_W-1:0] pwdata,
    output logic [cvsd_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output cvsd_pkg::cfg_t             cfg
);

    cvsd_pkg::cfg_t     cfg_reg;
    cvsd_pkg::reg_idx_t idx;

    assign idx    = cvsd_pkg::reg_idx_t'(paddr[3:2]);
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable       <= 1'b0;
            cfg_reg.vehicle_type <= cvsd_pkg::VT_REAR_PAIR;
            cfg_reg.wss_mode     <= cvsd_pkg::WSS_DIRECT;
            cfg_reg.speed_scale  <= cvsd_pkg::SCALE_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (idx)
                cvsd_pkg::REG_ENABLE:       cfg_reg.enable <= pwdata[0];
                cvsd_pkg::REG_VEHICLE_TYPE: cfg_reg.vehicle_type <= cvsd_pkg::vt_t'(pwdata[1:0]);
                cvsd_pkg::REG_WSS_MODE:     cfg_reg.wss_mode <= cvsd_pkg::wss_t'(pwdata[1:0]);
                cvsd_pkg::REG_SPEED_SCALE:  cfg_reg.speed_scale <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            cvsd_pkg::REG_ENABLE:       prdata[0]    = cfg_reg.enable;
            cvsd_pkg::REG_VEHICLE_TYPE: prdata[1:0]  = cfg_reg.vehicle_type;
            cvsd_pkg::REG_WSS_MODE:     prdata[1:0]  = cfg_reg.wss_mode;
            cvsd_pkg::REG_SPEED_SCALE:  prdata[15:0] = cfg_reg.speed_scale;
        endcase
    end

endmodule

>>> design/cvsd_frame_decode.sv
// Frame layout decode: picks raw speed words and their sign per lane, and one divisor per frame.
module cvsd_frame_decode (
    input  cvsd_pkg::cfg_t           cfg,
    input  logic [10:0]              can_id,
    input  logic [7:0][7:0]          payload,
    output cvsd_pkg::lane_raw_t      raw [cvsd_pkg::LANES],
    output cvsd_pkg::den_t           den,
    output cvsd_pkg::frame_flags_t   flags
);

    always_comb begin
        logic        direct_ok;
        logic        wheels_ok;
        logic [12:0] pair_sum;
        logic [15:0] word;

        direct_ok = 1'b0;
        wheels_ok = 1'b0;
        den       = cvsd_pkg::DEN_1;
        pair_sum  = '0;
        word      = '0;
        for (int i = 0; i < cvsd_pkg::LANES; i++) begin
            raw[i] = '0;
        end

        if (cfg.enable) begin
            unique case (cfg.vehicle_type)
                cvsd_pkg::VT_REAR_PAIR: begin
                    if (can_id == cvsd_pkg::ID_REAR_PAIR) begin
                        pair_sum = 13'({payload[5][3:0], payload[4]})
                                 + 13'({payload[7][3:0], payload[6]});
                        raw[0].mag = 16'(pair_sum >> 5);
                        direct_ok  = 1'b1;
                    end
                end
                cvsd_pkg::VT_DUAL_ID: begin
                    if (can_id == cvsd_pkg::ID_SPEED_12) begin
                        raw[0].mag = 16'({payload[1][3:0], payload[0]});
                        den        = cvsd_pkg::DEN_10;
                        direct_ok  = 1'b1;
                    end else if (can_id == cvsd_pkg::ID_WHEEL_LE) begin
                        for (int i = 0; i < cvsd_pkg::LANES; i++) begin
                            word       = {payload[2*i+1], payload[2*i]};
                            raw[i].neg = word[15];
                            raw[i].mag = word[15] ? 16'(-word) : word;
                        end
                        den       = cvsd_pkg::DEN_16;
                        wheels_ok = 1'b1;
                    end
                end
                cvsd_pkg::VT_BE_WORD: begin
                    if (can_id == cvsd_pkg::ID_SPEED_BE) begin
                        raw[0].mag = {payload[2], payload[3]};
                        den        = cvsd_pkg::DEN_16;
                        direct_ok  = 1'b1;
                    end
                end
                cvsd_pkg::VT_WHEEL_OFFS: begin
                    if (can_id == cvsd_pkg::ID_WHEEL_BE) begin
                        for (int i = 0; i < cvsd_pkg::LANES; i++) begin
                            word       = {payload[2*i], payload[2*i+1]};
                            raw[i].neg = word < cvsd_pkg::WHEEL_OFFSET;
                            raw[i].mag = (word < cvsd_pkg::WHEEL_OFFSET)
                                       ? cvsd_pkg::WHEEL_OFFSET - word
                                       : word - cvsd_pkg::WHEEL_OFFSET;
                        end
                        den       = cvsd_pkg::DEN_100;
                        wheels_ok = 1'b1;
                    end
                end
            endcase
        end

        flags.wheels_ok = wheels_ok;
        flags.speed_ok  = (direct_ok && (cfg.wss_mode == cvsd_pkg::WSS_DIRECT))
                       || (wheels_ok && (cfg.wss_mode != cvsd_pkg::WSS_DIRECT));
    end

endmodule

>>> design/cvsd_lane_scale.sv
// One speed lane: gain multiply, fraction shift, divide by constant, saturate.
module cvsd_lane_scale #(
    parameter int FRAC_BITS = cvsd_pkg::SPEED_FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  cvsd_pkg::stage_en_t                en,
    input  logic [cvsd_pkg::SCALE_W-1:0]       scale,
    input  cvsd_pkg::lane_raw_t                raw_in,
    input  cvsd_pkg::den_t                     den_in,
    output logic signed [cvsd_pkg::SPD_W-1:0]  speed_out
);

    // raw * gain * 2^F / 2^14: at most one of these is non-zero
    localparam int LSH = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
    localparam int RSH = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
    localparam logic [31:0] SPD_LIM = 32'(1) << (cvsd_pkg::SPD_W - 1);

    logic [31:0]          prod_reg;
    logic                 neg2_reg;
    cvsd_pkg::den_t       den2_reg;

    logic [cvsd_pkg::SHIFT_W-1:0] shifted;
    logic [31:0]          mag32;
    logic [31:0]          recip;
    logic [63:0]          rprod_reg;
    logic [31:0]          mag3_reg;
    logic                 neg3_reg;
    cvsd_pkg::den_t       den3_reg;

    logic [31:0]          quot;
    logic [cvsd_pkg::SPD_W-1:0] spd_next;
    logic [cvsd_pkg::SPD_W-1:0] spd_reg;

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            prod_reg <= 32'(raw_in.mag) * 32'(scale);
            neg2_reg <= raw_in.neg;
            den2_reg <= den_in;
        end
    end

    // Beyond 32 bits every divisor still saturates, so clamp before dividing
    assign shifted = (cvsd_pkg::SHIFT_W'(prod_reg) << LSH) >> RSH;
    assign mag32   = (|shifted[cvsd_pkg::SHIFT_W-1:32]) ? '1 : shifted[31:0];
    assign recip   = (den2_reg == cvsd_pkg::DEN_100) ? cvsd_pkg::RECIP_100
                                                     : cvsd_pkg::RECIP_10;

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            rprod_reg <= 64'(mag32) * 64'(recip);
            mag3_reg  <= mag32;
            neg3_reg  <= neg2_reg;
            den3_reg  <= den2_reg;
        end
    end

    always_comb begin
        unique case (den3_reg)
            cvsd_pkg::DEN_1:   quot = mag3_reg;
            cvsd_pkg::DEN_16:  quot = mag3_reg >> 4;
            cvsd_pkg::DEN_10:  quot = 32'(rprod_reg >> cvsd_pkg::SHIFT_10);
            cvsd_pkg::DEN_100: quot = 32'(rprod_reg >> cvsd_pkg::SHIFT_100);
        endcase
        // magnitude division truncates toward zero; sign goes back on after
        if (neg3_reg) begin
            spd_next = (quot >= SPD_LIM) ? cvsd_pkg::SPD_W'(SPD_LIM)
                                         : cvsd_pkg::SPD_W'(-quot);
        end else begin
            spd_next = (quot >= SPD_LIM) ? cvsd_pkg::SPD_W'(SPD_LIM - 32'd1)
                                         : cvsd_pkg::SPD_W'(quot);
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            spd_reg <= spd_next;
        end
    end

    assign speed_out = signed'(spd_reg);

endmodule

>>> design/cvsd_out_stage.sv
// Result register: wheel averages, vehicle speed select and field gating.
module cvsd_out_stage (
    input  logic                               aclk,
    input  logic                               load,
    input  cvsd_pkg::frame_flags_t             flags,
    input  cvsd_pkg::wss_t                     wss_mode,
    input  logic signed [cvsd_pkg::SPD_W-1:0]  lane_speed [cvsd_pkg::LANES],
    output logic                               speed_valid,
    output logic signed [cvsd_pkg::SPD_W-1:0]  vehicle_speed,
    output logic                               wheels_valid,
    output logic signed [cvsd_pkg::SPD_W-1:0]  wheel_speed [cvsd_pkg::LANES]
);

    logic signed [cvsd_pkg::SPD_W:0]   front_sum;
    logic signed [cvsd_pkg::SPD_W:0]   rear_sum;
    logic signed [cvsd_pkg::SPD_W:0]   all_sum;
    logic signed [cvsd_pkg::SPD_W-1:0] front_avg;
    logic signed [cvsd_pkg::SPD_W-1:0] rear_avg;
    logic signed [cvsd_pkg::SPD_W-1:0] all_avg;
    logic signed [cvsd_pkg::SPD_W-1:0] speed_next;

    logic                              speed_valid_reg;
    logic signed [cvsd_pkg::SPD_W-1:0] speed_reg;
    logic                              wheels_valid_reg;
    logic signed [cvsd_pkg::SPD_W-1:0] wheel_reg [cvsd_pkg::LANES];

    // averages floor: arithmetic shift of the widened sum
    assign front_sum = (cvsd_pkg::SPD_W+1)'(lane_speed[0]) + (cvsd_pkg::SPD_W+1)'(lane_speed[1]);
    assign rear_sum  = (cvsd_pkg::SPD_W+1)'(lane_speed[2]) + (cvsd_pkg::SPD_W+1)'(lane_speed[3]);
    assign front_avg = cvsd_pkg::SPD_W'(front_sum >>> 1);
    assign rear_avg  = cvsd_pkg::SPD_W'(rear_sum >>> 1);
    assign all_sum   = (cvsd_pkg::SPD_W+1)'(front_avg) + (cvsd_pkg::SPD_W+1)'(rear_avg);
    assign all_avg   = cvsd_pkg::SPD_W'(all_sum >>> 1);

    always_comb begin
        unique case (wss_mode)
            cvsd_pkg::WSS_DIRECT: speed_next = lane_speed[0];
            cvsd_pkg::WSS_FRONT:  speed_next = front_avg;
            cvsd_pkg::WSS_REAR:   speed_next = rear_avg;
            cvsd_pkg::WSS_ALL:    speed_next = all_avg;
        endcase
        if (!flags.speed_ok) begin
            speed_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            speed_valid_reg  <= flags.speed_ok;
            speed_reg        <= speed_next;
            wheels_valid_reg <= flags.wheels_ok;
            for (int i = 0; i < cvsd_pkg::LANES; i++) begin
                wheel_reg[i] <= flags.wheels_ok ? lane_speed[i] : '0;
            end
        end
    end

    assign speed_valid   = speed_valid_reg;
    assign vehicle_speed = speed_reg;
    assign wheels_valid  = wheels_valid_reg;
    assign wheel_speed   = wheel_reg;

endmodule

>>> design/can_vehicle_speed_decoder.sv
// Top level of the CAN vehicle speed decoder.
//
// Decodes one CAN frame per transaction into a vehicle speed and four wheel
// speeds, signed km/h with SPEED_FRAC_BITS fraction bits, scaled by the
// Q2.14 gain and saturated to 26 bits. Exactly one result transaction
// leaves for every accepted frame. The datapath is a five-register pipeline
// (frame register, gain multiply, reciprocal multiply for the divide by 10
// or 100, saturation, result register), and a new frame can be taken every
// cycle while m_ready does not hold the output; the two multipliers in each
// of the four speed lanes set the depth. Each pipeline register holds when
// it is full and the one after it cannot take its content, so frames keep
// entering while a result waits on m_ready until the empty stages fill.
// Registers (APB, 32-bit): 0x0 enable, 0x4 vehicle_type, 0x8 wss_mode, 0xC
// speed_scale; change them only while no transaction is in flight.
`include "can_vehicle_speed_decoder_defines.svh"

module can_vehicle_speed_decoder #(
    parameter int SPEED_FRAC_BITS = cvsd_pkg::SPEED_FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cvsd_pkg::ADDR_W-1:0]        paddr,
    input  logic [cvsd_pkg::DATA_W-1:0]        pwdata,
    output logic [cvsd_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [10:0]                        s_can_id,
    input  logic [7:0]                         s_byte0,
    input  logic [7:0]                         s_byte1,
    input  logic [7:0]                         s_byte2,
    input  logic [7:0]                         s_byte3,
    input  logic [7:0]                         s_byte4,
    input  logic [7:0]                         s_byte5,
    input  logic [7:0]                         s_byte6,
    input  logic [7:0]                         s_byte7,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_speed_valid,
    output logic signed [cvsd_pkg::SPD_W-1:0]  m_vehicle_speed,
    output logic                               m_wheels_valid,
    output logic signed [cvsd_pkg::SPD_W-1:0]  m_wheel_left_front,
    output logic signed [cvsd_pkg::SPD_W-1:0]  m_wheel_right_front,
    output logic signed [cvsd_pkg::SPD_W-1:0]  m_wheel_left_rear,
    output logic signed [cvsd_pkg::SPD_W-1:0]  m_wheel_right_rear
);

    cvsd_pkg::cfg_t          cfg;

    logic [4:0]              vld_reg;
    logic [4:0]              rdy;
    cvsd_pkg::stage_en_t     stage_en;

    logic [10:0]             id_reg;
    logic [7:0][7:0]         payload_reg;

    cvsd_pkg::lane_raw_t     raw [cvsd_pkg::LANES];
    cvsd_pkg::den_t          den;
    cvsd_pkg::frame_flags_t  flags_next;
    cvsd_pkg::frame_flags_t  flags1_reg;
    cvsd_pkg::frame_flags_t  flags2_reg;
    cvsd_pkg::frame_flags_t  flags3_reg;

    logic signed [cvsd_pkg::SPD_W-1:0] lane_speed [cvsd_pkg::LANES];
    logic signed [cvsd_pkg::SPD_W-1:0] wheel_speed [cvsd_pkg::LANES];

    logic                    wheels_zero;
    logic                    direct_mode;

    cvsd_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // a stage loads when it is empty or the stage after it moves on
    always_comb begin
        rdy[4] = !vld_reg[4] || m_ready;
        rdy[3] = !vld_reg[3] || rdy[4];
        rdy[2] = !vld_reg[2] || rdy[3];
        rdy[1] = !vld_reg[1] || rdy[2];
        rdy[0] = !vld_reg[0] || rdy[1];
    end

    assign s_ready     = rdy[0];
    assign m_valid     = vld_reg[4];
    assign stage_en.s2 = rdy[1];
    assign stage_en.s3 = rdy[2];
    assign stage_en.s4 = rdy[3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < 5; k++) begin
                if (rdy[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            id_reg      <= s_can_id;
            payload_reg <= {s_byte7, s_byte6, s_byte5, s_byte4,
                            s_byte3, s_byte2, s_byte1, s_byte0};
        end
        if (rdy[1]) begin
            flags1_reg <= flags_next;
        end
        if (rdy[2]) begin
            flags2_reg <= flags1_reg;
        end
        if (rdy[3]) begin
            flags3_reg <= flags2_reg;
        end
    end

    cvsd_frame_decode u_decode (
        .cfg     (cfg),
        .can_id  (id_reg),
        .payload (payload_reg),
        .raw     (raw),
        .den     (den),
        .flags   (flags_next)
    );

    for (genvar g = 0; g < cvsd_pkg::LANES; g++) begin : g_lane
        cvsd_lane_scale #(
            .FRAC_BITS (SPEED_FRAC_BITS)
        ) u_lane (
            .aclk      (aclk),
            .en        (stage_en),
            .scale     (cfg.speed_scale),
            .raw_in    (raw[g]),
            .den_in    (den),
            .speed_out (lane_speed[g])
        );
    end

    cvsd_out_stage u_out (
        .aclk          (aclk),
        .load          (rdy[4]),
        .flags         (flags3_reg),
        .wss_mode      (cfg.wss_mode),
        .lane_speed    (lane_speed),
        .speed_valid   (m_speed_valid),
        .vehicle_speed (m_vehicle_speed),
        .wheels_valid  (m_wheels_valid),
        .wheel_speed   (wheel_speed)
    );

    assign m_wheel_left_front  = wheel_speed[0];
    assign m_wheel_right_front = wheel_speed[1];
    assign m_wheel_left_rear   = wheel_speed[2];
    assign m_wheel_right_rear  = wheel_speed[3];

    assign wheels_zero = (m_wheel_left_front == '0) && (m_wheel_right_front == '0)
                      && (m_wheel_left_rear == '0) && (m_wheel_right_rear == '0);
    assign direct_mode = (cfg.wss_mode == cvsd_pkg::WSS_DIRECT);

    `CVSD_ASSERT_NXT(a_frame_captured, s_valid && s_ready, vld_reg[0])
    `CVSD_ASSERT_IMP(a_speed_zero_when_invalid, m_valid && !m_speed_valid, m_vehicle_speed == '0)
    `CVSD_ASSERT_IMP(a_wheels_zero_when_invalid, m_valid && !m_wheels_valid, wheels_zero)
    `CVSD_ASSERT_IMP(a_disabled_no_result, m_valid && !cfg.enable, !m_speed_valid && !m_wheels_valid)
    `CVSD_ASSERT_IMP(a_wheels_direct_mode, m_valid && m_wheels_valid && direct_mode, !m_speed_valid)

endmodule
